[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
package rau_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } rau_state_t;

  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_SUB    = 4'd1;
  localparam logic [3:0] CMD_MUL    = 4'd2;
  localparam logic [3:0] CMD_DIV    = 4'd3;
  localparam logic [3:0] CMD_LT     = 4'd4;
  localparam logic [3:0] CMD_LE     = 4'd5;
  localparam logic [3:0] CMD_GT     = 4'd6;
  localparam logic [3:0] CMD_GE     = 4'd7;
  localparam logic [3:0] CMD_REDUCE = 4'd8;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DIVZERO = 2'd1;
  localparam logic [1:0] STAT_OVF     = 2'd2;

endpackage

[rtl/rau_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div #(
  parameter int N = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [N-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [N-1:0]  rem_r, rem_nxt;
  logic [N-1:0]  quo_r, quo_nxt;
  logic [N-1:0]  dvs_r, dvs_nxt;
  logic [N:0]    sh;
  logic          ge;

  always_comb begin
    sh       = {rem_r, quo_r[N-1]};
    ge       = (sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? N'(sh - {1'b0, dvs_r}) : sh[N-1:0];
      quo_nxt = {quo_r[N-2:0], ge};
      cnt_nxt = CW'(cnt_r + 1'b1);
      if (cnt_r == CW'(N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Rational arithmetic unit: add, sub, mul, div, compare and reduce on signed
// fractions A = a_num/a_den and B = b_num/b_den, computed at WIDTH bits.
// Input channel (in_valid/in_ready) carries cmd and the four operand fields;
// result channel (out_valid/out_ready) returns one result per input request:
// res_num, res_den, cmp_true and status (ok, divide by zero, overflow).
// One request is in flight at a time; in_ready is high only when idle.
// Sequencing from accept to out_valid:
//   unused opcode or divide by zero: straight to the output state
//   add/sub/mul/div/compare: three passes through one shared
//     WIDTH x WIDTH multiplier, then a final add/compare state
//   reduce: a binary gcd loop of shift or subtract steps (one per cycle),
//     then two passes through a restoring divider of WIDTH+1 steps.
// Results sit in an output register until taken; a stalled receiver simply
// holds the block in its output state. Synchronous active-low reset returns
// the sequencer to idle with no result pending.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_cmd,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_res_num,
  output logic [31:0] out_res_den,
  output logic        out_cmp_true,
  output logic [1:0]  out_status
);
  import rau_pkg::*;

  localparam int W  = WIDTH;
  localparam int P  = 2 * W;
  localparam int KW = $clog2(W + 2);

  rau_state_t state_r, state_nxt;

  logic [3:0]          cmd_r, cmd_nxt;
  logic signed [W-1:0] an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [1:0]          step_r, step_nxt;
  logic signed [P-1:0] m0_r, m0_nxt, m1_r, m1_nxt, m2_r, m2_nxt;
  logic [W:0]          gx_r, gx_nxt, gy_r, gy_nxt, g_r, g_nxt, qn_r, qn_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [31:0]         num_r, num_nxt, den_r, den_nxt;
  logic                cmp_r, cmp_nxt;
  logic [1:0]          stat_r, stat_nxt;

  // multiplier operands
  logic signed [W-1:0] mx, my;
  logic signed [P-1:0] prod;

  // finish-stage arithmetic
  logic signed [P:0]   sum;
  logic                n_fit, d_fit;

  // reduce helpers
  logic signed [W:0]   anx, adx;
  logic [W:0]          mn, md;
  logic [W:0]          qd_neg, qn_neg;

  // divider hookup
  logic                div_start, div_done;
  logic [W:0]          div_dividend, div_quo;

  logic                acc;
  logic signed [W-1:0] in_an, in_ad, in_bn, in_bd;

  assign in_an = in_a_num[W-1:0];
  assign in_ad = in_a_den[W-1:0];
  assign in_bn = in_b_num[W-1:0];
  assign in_bd = in_b_den[W-1:0];
  assign acc   = in_valid && in_ready;

  // Shared multiplier: step 0 a_num x (b_num for mul, else b_den),
  // step 1 b_num x a_den, step 2 a_den x (b_num for div, else b_den).
  always_comb begin
    case (step_r)
      2'd0: begin
        mx = an_r;
        my = (cmd_r == CMD_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mx = bn_r;
        my = ad_r;
      end
      default: begin
        mx = ad_r;
        my = (cmd_r == CMD_DIV) ? bn_r : bd_r;
      end
    endcase
  end
  assign prod = mx * my;

  always_comb begin
    case (cmd_r)
      CMD_ADD: sum = (P+1)'(m0_r) + (P+1)'(m1_r);
      CMD_SUB: sum = (P+1)'(m0_r) - (P+1)'(m1_r);
      default: sum = (P+1)'(m0_r);
    endcase
  end
  assign n_fit = (sum == (P+1)'($signed(sum[W-1:0])));
  assign d_fit = (m2_r == P'($signed(m2_r[W-1:0])));

  // magnitudes of A for reduce, WIDTH+1 bits so the most negative value fits
  assign anx    = (W+1)'(an_r);
  assign adx    = (W+1)'(ad_r);
  assign mn     = anx[W] ? (W+1)'(-anx) : anx;
  assign md     = adx[W] ? (W+1)'(-adx) : adx;
  assign qn_neg = (W+1)'(-qn_r);
  assign qd_neg = (W+1)'(-div_quo);

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    an_nxt       = an_r;
    ad_nxt       = ad_r;
    bn_nxt       = bn_r;
    bd_nxt       = bd_r;
    step_nxt     = step_r;
    m0_nxt       = m0_r;
    m1_nxt       = m1_r;
    m2_nxt       = m2_r;
    gx_nxt       = gx_r;
    gy_nxt       = gy_r;
    g_nxt        = g_r;
    k_nxt        = k_r;
    qn_nxt       = qn_r;
    num_nxt      = num_r;
    den_nxt      = den_r;
    cmp_nxt      = cmp_r;
    stat_nxt     = stat_r;
    div_start    = 1'b0;
    div_dividend = mn;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd_nxt  = in_cmd;
          an_nxt   = in_an;
          ad_nxt   = in_ad;
          bn_nxt   = in_bn;
          bd_nxt   = in_bd;
          step_nxt = 2'd0;
          num_nxt  = '0;
          den_nxt  = '0;
          cmp_nxt  = 1'b0;
          stat_nxt = STAT_OK;
          if (in_cmd > CMD_REDUCE) begin
            state_nxt = ST_OUT;
          end else if (in_ad == '0 || (in_cmd != CMD_REDUCE && in_bd == '0) ||
                       (in_cmd == CMD_DIV && in_bn == '0)) begin
            stat_nxt  = STAT_DIVZERO;
            state_nxt = ST_OUT;
          end else if (in_cmd == CMD_REDUCE) begin
            state_nxt = ST_GCD;
            k_nxt     = '0;
            // loaded from the registered operands on the next cycle
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        case (step_r)
          2'd0:    m0_nxt = prod;
          2'd1:    m1_nxt = prod;
          default: m2_nxt = prod;
        endcase
        step_nxt = 2'(step_r + 1'b1);
        if (step_r == 2'd2) state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (cmd_r inside {[CMD_LT:CMD_GE]}) begin
          case (cmd_r)
            CMD_LT:  cmp_nxt = (m0_r <  m1_r);
            CMD_LE:  cmp_nxt = (m0_r <= m1_r);
            CMD_GT:  cmp_nxt = (m0_r >  m1_r);
            default: cmp_nxt = (m0_r >= m1_r);
          endcase
        end else begin
          num_nxt  = 32'($signed(sum[W-1:0]));
          den_nxt  = 32'($signed(m2_r[W-1:0]));
          stat_nxt = (n_fit && d_fit) ? STAT_OK : STAT_OVF;
        end
        state_nxt = ST_OUT;
      end

      ST_GCD: begin
        // gx/gy are loaded on the first cycle, flagged by step 0
        if (step_r == 2'd0) begin
          gx_nxt   = mn;
          gy_nxt   = md;
          step_nxt = 2'd1;
        end else if (gx_r == '0 || gx_r == gy_r) begin
          g_nxt     = (W+1)'(gy_r << k_r);
          div_start = 1'b1;
          state_nxt = ST_DIVN;
        end else if (!gx_r[0] && !gy_r[0]) begin
          gx_nxt = gx_r >> 1;
          gy_nxt = gy_r >> 1;
          k_nxt  = KW'(k_r + 1'b1);
        end else if (!gx_r[0]) begin
          gx_nxt = gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_nxt = gy_r >> 1;
        end else if (gx_r > gy_r) begin
          gx_nxt = gx_r - gy_r;
        end else begin
          gy_nxt = gy_r - gx_r;
        end
      end

      ST_DIVN: begin
        if (div_done) begin
          qn_nxt       = div_quo;
          div_start    = 1'b1;
          div_dividend = md;
          state_nxt    = ST_DIVD;
        end
      end

      ST_DIVD: begin
        if (div_done) begin
          num_nxt   = 32'($signed(an_r[W-1] ? qn_neg[W-1:0] : qn_r[W-1:0]));
          den_nxt   = 32'($signed(ad_r[W-1] ? qd_neg[W-1:0] : div_quo[W-1:0]));
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  rau_div #(.N(W + 1)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g_nxt),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    cmd_r  <= cmd_nxt;
    an_r   <= an_nxt;
    ad_r   <= ad_nxt;
    bn_r   <= bn_nxt;
    bd_r   <= bd_nxt;
    m0_r   <= m0_nxt;
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    g_r    <= g_nxt;
    k_r    <= k_nxt;
    qn_r   <= qn_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    cmp_r  <= cmp_nxt;
    stat_r <= stat_nxt;
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = (state_r == ST_OUT);
  assign out_res_num  = num_r;
  assign out_res_den  = den_r;
  assign out_cmp_true = cmp_r;
  assign out_status   = stat_r;

endmodule

[rtl/rau_checker.sv]
`timescale 1ns / 1ps
module rau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [3:0]  in_cmd,
  input logic [31:0] in_a_num,
  input logic [31:0] in_a_den,
  input logic [31:0] in_b_num,
  input logic [31:0] in_b_den,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_res_num,
  input logic [31:0] out_res_den,
  input logic        out_cmp_true,
  input logic [1:0]  out_status
);
  import rau_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num) &&
    $stable(out_res_den) && $stable(out_status) && $stable(out_cmp_true))
    else $error("stalled result changed");

  // one request in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_DIVZERO |->
    out_res_num == '0 && out_res_den == '0 && !out_cmp_true)
    else $error("divide-by-zero result not cleared");

  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmp_true |-> out_status == STAT_OK &&
    out_res_num == '0 && out_res_den == '0)
    else $error("compare result with payload");

  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready while result pending");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import rau_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        cmp;
    logic [1:0]  st;
  } frac_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_cmd = '0;
  logic [31:0] in_a_num = '0;
  logic [31:0] in_a_den = '0;
  logic [31:0] in_b_num = '0;
  logic [31:0] in_b_den = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_res_num;
  logic [31:0] out_res_den;
  logic        out_cmp_true;
  logic [1:0]  out_status;

  frac_result_t pending_results[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  no_stall = 1'b0;
  bit  took = 1'b0;
  int  rx_wait = 0;

  localparam int WATCHDOG_LIMIT = 4000;

  always #1 clk = ~clk;

  rational_arithmetic_unit u_dut (.*);

  // Exact math on wide vectors, then wrap to 32 bits.
  function automatic bit fits32(logic signed [65:0] v);
    return v >= -66'sd2147483648 && v <= 66'sd2147483647;
  endfunction

  function automatic logic [31:0] gcd32(logic [31:0] x, logic [31:0] y);
    logic [31:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_result_t compute_fraction(logic [3:0] cmd, logic [31:0] an_u,
      logic [31:0] ad_u, logic [31:0] bn_u, logic [31:0] bd_u);
    frac_result_t r;
    logic signed [65:0] an, ad, bn, bd, n, d, l, rr;
    logic [31:0] mn, md, g, qn, qd;
    an = $signed(an_u); ad = $signed(ad_u); bn = $signed(bn_u); bd = $signed(bd_u);
    r = '{num: '0, den: '0, cmp: 1'b0, st: STAT_OK};
    if (cmd > CMD_REDUCE) return r;
    if (ad == 0 || (cmd <= CMD_GE && bd == 0) || (cmd == CMD_DIV && bn == 0)) begin
      r.st = STAT_DIVZERO;
      return r;
    end
    case (cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        case (cmd)
          CMD_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
          CMD_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
          CMD_MUL: begin n = an * bn; d = ad * bd; end
          default: begin n = an * bd; d = ad * bn; end
        endcase
        r.num = n[31:0];
        r.den = d[31:0];
        if (!fits32(n) || !fits32(d)) r.st = STAT_OVF;
      end
      CMD_LT, CMD_LE, CMD_GT, CMD_GE: begin
        l = an * bd;
        rr = bn * ad;
        case (cmd)
          CMD_LT:  r.cmp = l < rr;
          CMD_LE:  r.cmp = l <= rr;
          CMD_GT:  r.cmp = l > rr;
          default: r.cmp = l >= rr;
        endcase
      end
      default: begin
        // magnitudes of -2^31 still fit as unsigned 32-bit
        mn = an < 0 ? -an_u : an_u;
        md = ad < 0 ? -ad_u : ad_u;
        g = gcd32(mn, md);
        if (g == 0) g = 1;
        qn = mn / g;
        qd = md / g;
        r.num = an < 0 ? -qn : qn;
        r.den = ad < 0 ? -qd : qd;
      end
    endcase
    return r;
  endfunction

  // Result checker and watchdog, sampled at the rising edge.
  always @(posedge clk) begin
    frac_result_t exp_r;
    took <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_res_num !== exp_r.num || out_res_den !== exp_r.den ||
              out_cmp_true !== exp_r.cmp || out_status !== exp_r.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: exp num %h den %h cmp %b st %0d, got %h %h %b %0d",
                       exp_r.num, exp_r.den, exp_r.cmp, exp_r.st,
                       out_res_num, out_res_den, out_cmp_true, out_status);
          end
        end
      end
    end
  end

  // Receiver: random stall before each result, none while no_stall is set.
  always @(negedge clk) begin
    int w;
    w = rx_wait;
    if (took) w = no_stall ? 0 : $urandom_range(9);
    else if (w > 0) w--;
    rx_wait <= w;
    out_ready <= rst_n && (w == 0);
  end

  // Valid stays high into the next request when no gap is drawn.
  task automatic send_request(logic [3:0] cmd, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = no_stall ? 0 : $urandom_range(9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(compute_fraction(cmd, an, ad, bn, bd));
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(20) - 10;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return $urandom_range(65535) - 32768;
      4: return ($urandom_range(30) + 1) * ($urandom_range(1000) - 500);
      default: return $urandom_range(2) - 1;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    for (int c = CMD_ADD; c <= CMD_REDUCE; c++)
      send_request(c[3:0], 32'd3, 32'd4, -32'd5, 32'd6);
    send_request(CMD_ADD, mx, 32'd1, mx, 32'd1);       // numerator overflow
    send_request(CMD_MUL, mn, mn, mn, mn);             // largest products
    send_request(CMD_SUB, mn, mx, mx, mn);
    send_request(CMD_ADD, mn, mn, mn, mn);
    send_request(CMD_DIV, 32'd7, 32'd2, 32'd0, 32'd5); // divide by zero numerator
    send_request(CMD_ADD, 32'd1, 32'd0, 32'd1, 32'd1); // zero a_den
    send_request(CMD_LT, 32'd1, 32'd2, 32'd1, 32'd0);  // zero b_den
    send_request(CMD_REDUCE, 32'd9, 32'd6, 32'd0, 32'd0); // b_den ignored
    send_request(CMD_REDUCE, 32'd0, -32'd8, 32'd1, 32'd1);
    send_request(CMD_REDUCE, mn, 32'd1, 32'd0, 32'd0);
    send_request(CMD_REDUCE, mn, mn, 32'd0, 32'd0);
    send_request(CMD_REDUCE, -32'd12, -32'd18, 32'd0, 32'd0);
    send_request(CMD_GE, mn, -32'd1, mx, 32'd1);
    send_request(4'd9, 32'd1, 32'd0, 32'd1, 32'd0);    // unused opcodes
    send_request(4'd15, mn, mx, mn, mx);
  endtask

  task automatic test_random(int n);
    logic [3:0] cmd;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) no_stall = ($urandom_range(3) == 0);
      cmd = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
      send_request(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    no_stall = 1'b0;
  endtask

  // Sender holds off until the block has drained completely.
  task automatic test_drain_pause();
    send_request(CMD_REDUCE, $urandom(), $urandom(), 32'd0, 32'd1);
    drop_valid();
    wait (pending_results.size() == 0);
    repeat (150) @(negedge clk);
    send_request(CMD_DIV, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(800);
    test_drain_pause();
    test_random(825);
    drop_valid();
    wait (pending_results.size() == 0);
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rau_pkg.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
tb/testbench.sv
